>>> rtl/pidc_pkg.sv
// Shared types, widths and constants for the PID controller with dead band and clamps.
package pidc_pkg;

  // Fixed-point format of values and gains.
  localparam int FRAC_BITS = 8;

  localparam int MEAS_W   = 24;
  localparam int DRIVE_W  = 24;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int ERR_W    = MEAS_W + 1;
  localparam int INT_W    = 21;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Operating modes.
  localparam logic [1:0] MODE_SPEED = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_POS   = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd7200;

  // Dead band half-widths in whole units, and the integral clamp.
  localparam int DB_SPEED_UNITS = 1;
  localparam int DB_LINE_UNITS  = 3;
  localparam int DB_POS_UNITS   = 10;
  localparam int INT_LIM_UNITS  = 3000;

  typedef struct packed {
    logic                      enable;
    logic [1:0]                mode;
    logic signed [MEAS_W-1:0]  target;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0]        out_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [INT_W-1:0] integral_sum;
    logic signed [ERR_W-1:0] last_error;
  } ctl_state_t;

endpackage

>>> rtl/pidc_calc.sv
// Single-pass PID arithmetic: error, dead band, integral clamp, gain products, output clamp.
module pidc_calc import pidc_pkg::*; (
  input  cfg_t                      cfg,
  input  ctl_state_t                state_cur,
  input  logic signed [MEAS_W-1:0]  measured,
  output logic signed [DRIVE_W-1:0] drive,
  output ctl_state_t                state_next
);

  localparam int SUM_W  = ERR_W + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + INT_W;
  localparam int D_W    = GAIN_W + DIFF_W;
  localparam int ACC_W  = D_W + 2;

  localparam logic signed [ERR_W-1:0] DB_SPEED = ERR_W'(DB_SPEED_UNITS * (1 << FRAC_BITS));
  localparam logic signed [ERR_W-1:0] DB_LINE  = ERR_W'(DB_LINE_UNITS * (1 << FRAC_BITS));
  localparam logic signed [ERR_W-1:0] DB_POS   = ERR_W'(DB_POS_UNITS * (1 << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] INT_LIM  = SUM_W'(INT_LIM_UNITS * (1 << FRAC_BITS));

  logic signed [ERR_W-1:0]  meas_x;
  logic signed [ERR_W-1:0]  target_x;
  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  band;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  int_sum;
  logic signed [INT_W-1:0]  int_new;
  logic signed [INT_W-1:0]  int_op;
  logic signed [DIFF_W-1:0] diff;
  logic signed [P_W-1:0]    p_prod;
  logic signed [I_W-1:0]    i_prod;
  logic signed [D_W-1:0]    d_prod;
  logic signed [ACC_W-1:0]  p_term;
  logic signed [ACC_W-1:0]  i_term;
  logic signed [ACC_W-1:0]  d_term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  olim;
  logic signed [ACC_W-1:0]  acc_clamped;

  always_comb begin
    meas_x   = ERR_W'(measured);
    target_x = ERR_W'($signed(cfg.target));

    case (cfg.mode)
      MODE_LINE: begin
        err_raw = meas_x - target_x;
        band    = DB_LINE;
      end
      MODE_POS: begin
        err_raw = target_x - meas_x;
        band    = DB_POS;
      end
      default: begin
        err_raw = target_x - meas_x;
        band    = DB_SPEED;
      end
    endcase

    err = (err_raw >= -band && err_raw <= band) ? '0 : err_raw;

    // The integral saturates at the clamp and sits exactly on the negative bound below it.
    int_sum = SUM_W'(state_cur.integral_sum) + SUM_W'(err);
    if (int_sum >= INT_LIM) begin
      int_new = INT_W'(INT_LIM);
    end else if (int_sum < -INT_LIM) begin
      int_new = INT_W'(-INT_LIM);
    end else begin
      int_new = INT_W'(int_sum);
    end

    int_op = (cfg.mode == MODE_SPEED) ? int_new : state_cur.integral_sum;
    diff   = DIFF_W'(err) - DIFF_W'(state_cur.last_error);

    p_prod = P_W'($signed(cfg.gain_p)) * P_W'(err);
    i_prod = I_W'($signed(cfg.gain_i)) * I_W'(int_op);
    d_prod = D_W'($signed(cfg.gain_d)) * D_W'(diff);

    // Arithmetic shifts truncate each product toward minus infinity.
    p_term = ACC_W'(p_prod >>> FRAC_BITS);
    i_term = (cfg.mode == MODE_POS) ? '0 : ACC_W'(i_prod >>> FRAC_BITS);
    d_term = (cfg.mode == MODE_SPEED) ? '0 : ACC_W'(d_prod >>> FRAC_BITS);
    acc    = p_term + i_term + d_term;

    olim = ACC_W'(cfg.out_limit) << FRAC_BITS;
    if (acc > olim) begin
      acc_clamped = olim;
    end else if (acc < -olim) begin
      acc_clamped = -olim;
    end else begin
      acc_clamped = acc;
    end

    drive      = '0;
    state_next = state_cur;
    if (cfg.mode != MODE_NONE) begin
      if (cfg.enable) begin
        drive                 = DRIVE_W'(acc_clamped);
        state_next.last_error = err;
        if (cfg.mode == MODE_SPEED) begin
          state_next.integral_sum = int_new;
        end
      end else begin
        if (cfg.mode == MODE_SPEED) begin
          state_next.last_error = '0;
        end else if (cfg.mode == MODE_LINE) begin
          state_next.last_error   = '0;
          state_next.integral_sum = '0;
        end
      end
    end
  end

endmodule

>>> rtl/pid_controller_deadband_clamp.sv
// Top level of the PID controller with dead band and clamps: registers and handshakes.
//
//  channel  signals                                direction  payload
//  in       in_valid, in_ready, measured           input      one measured sample
//  out      out_valid, out_ready, drive            output     one drive value
//  cfg      cfg_valid, cfg_ready, cfg_index/data   input      register write
//
// One item a cycle is sustained while the output is taken; an accepted item sits in the
// input register while the arithmetic runs, and the result register takes the drive value
// once the output is free, which makes the result visible. The integral and last error
// update as the item moves into the result register. A stalled output holds the
// pipeline; an empty input register still takes an item while the result register
// waits. Reset is synchronous; configuration writes are always accepted.
module pid_controller_deadband_clamp import pidc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [MEAS_W-1:0]     measured,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DRIVE_W-1:0]    drive,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t                      cfg;
  ctl_state_t                state_cur;
  ctl_state_t                state_next;
  logic                      s1_valid;
  logic signed [MEAS_W-1:0]  s1_measured;
  logic                      advance;
  logic signed [DRIVE_W-1:0] drive_next;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  pidc_calc u_calc (
    .cfg        (cfg),
    .state_cur  (state_cur),
    .measured   (s1_measured),
    .drive      (drive_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b0;
      cfg.mode      <= MODE_SPEED;
      cfg.target    <= '0;
      cfg.gain_p    <= '0;
      cfg.gain_i    <= '0;
      cfg.gain_d    <= '0;
      cfg.out_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE: cfg.enable    <= cfg_data[0];
        REG_MODE:   cfg.mode      <= cfg_data[1:0];
        REG_TARGET: cfg.target    <= $signed(cfg_data[MEAS_W-1:0]);
        REG_GAIN_P: cfg.gain_p    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I: cfg.gain_i    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D: cfg.gain_d    <= $signed(cfg_data[GAIN_W-1:0]);
        REG_LIMIT:  cfg.out_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state_cur <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state_cur <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_measured <= measured;
    end
    if (advance) begin
      drive <= drive_next;
    end
  end

endmodule

>>> sim/pidc_checker.sv
// Checker for the PID controller: watches all channels, predicts each drive value and compares.
`timescale 1ns / 1ps

module pidc_checker import pidc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [MEAS_W-1:0]  measured,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DRIVE_W-1:0] drive,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        fails,
  output int                        outstanding
);

  // Shadow copy of the configuration registers.
  logic                     en_q;
  logic [1:0]               mode_q;
  logic signed [MEAS_W-1:0] tgt_q;
  logic signed [GAIN_W-1:0] kp_q;
  logic signed [GAIN_W-1:0] ki_q;
  logic signed [GAIN_W-1:0] kd_q;
  logic [LIMIT_W-1:0]       lim_q;

  // Shadow copy of the controller state.
  logic signed [INT_W-1:0]  integ_q;
  logic signed [ERR_W-1:0]  lerr_q;

  logic signed [DRIVE_W-1:0] drive_exp_q[$];

  task automatic report_mismatch(input string what);
    $display("ERROR: %s (t=%0t)", what, $time);
    fails++;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ENABLE: en_q = data[0];
      REG_MODE:   mode_q = data[1:0];
      REG_TARGET: tgt_q = data[MEAS_W-1:0];
      REG_GAIN_P: kp_q = data[GAIN_W-1:0];
      REG_GAIN_I: ki_q = data[GAIN_W-1:0];
      REG_GAIN_D: kd_q = data[GAIN_W-1:0];
      REG_LIMIT:  lim_q = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Computes the drive value for one sample and advances the shadow state.
  task automatic pid_drive(input logic signed [MEAS_W-1:0] meas,
                           output logic signed [DRIVE_W-1:0] drv);
    longint m, e, s, acc, olim, ilim, band;
    m    = meas;
    olim = longint'(lim_q) << FRAC_BITS;
    ilim = longint'(INT_LIM_UNITS) << FRAC_BITS;
    acc  = 0;
    if (mode_q == MODE_NONE) begin
      drv = '0;
    end else if (!en_q) begin
      // Disabled: the clears depend on the mode.
      if (mode_q == MODE_SPEED) begin
        lerr_q = '0;
      end else if (mode_q == MODE_LINE) begin
        lerr_q = '0;
        integ_q = '0;
      end
      drv = '0;
    end else begin
      case (mode_q)
        MODE_SPEED: begin
          e = longint'(tgt_q) - m;
          band = longint'(DB_SPEED_UNITS) << FRAC_BITS;
        end
        MODE_LINE: begin
          e = m - longint'(tgt_q);
          band = longint'(DB_LINE_UNITS) << FRAC_BITS;
        end
        default: begin
          e = longint'(tgt_q) - m;
          band = longint'(DB_POS_UNITS) << FRAC_BITS;
        end
      endcase
      if (e >= -band && e <= band) e = 0;
      case (mode_q)
        MODE_SPEED: begin
          s = longint'(integ_q) + e;
          if (s >= ilim) s = ilim;
          else if (s < -ilim) s = -ilim;
          integ_q = s[INT_W-1:0];
          acc = ((longint'(kp_q) * e) >>> FRAC_BITS) + ((longint'(ki_q) * s) >>> FRAC_BITS);
        end
        MODE_LINE: begin
          acc = ((longint'(kp_q) * e) >>> FRAC_BITS)
              + ((longint'(ki_q) * longint'(integ_q)) >>> FRAC_BITS)
              + ((longint'(kd_q) * (e - longint'(lerr_q))) >>> FRAC_BITS);
        end
        default: begin
          acc = ((longint'(kp_q) * e) >>> FRAC_BITS)
              + ((longint'(kd_q) * (e - longint'(lerr_q))) >>> FRAC_BITS);
        end
      endcase
      lerr_q = e[ERR_W-1:0];
      if (acc > olim) acc = olim;
      if (acc < -olim) acc = -olim;
      drv = acc[DRIVE_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    logic signed [DRIVE_W-1:0] d;
    logic signed [DRIVE_W-1:0] want;
    if (rst) begin
      en_q    = 1'b0;
      mode_q  = MODE_SPEED;
      tgt_q   = '0;
      kp_q    = '0;
      ki_q    = '0;
      kd_q    = '0;
      lim_q   = LIMIT_RESET;
      integ_q = '0;
      lerr_q  = '0;
      drive_exp_q.delete();
      outstanding <= 0;
    end else begin
      // A write and an item on the same edge: the item sees the new value.
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        pid_drive(measured, d);
        drive_exp_q.push_back(d);
      end
      if (out_valid && out_ready) begin
        if (drive_exp_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d with no item pending", drive));
        end else begin
          want = drive_exp_q.pop_front();
          if (drive !== want)
            report_mismatch($sformatf("drive got %0d, expected %0d", drive, want));
        end
      end
      outstanding <= drive_exp_q.size();
    end
  end

endmodule

>>> sim/tb_pid_controller_deadband_clamp.sv
// Testbench top for the PID controller: stimulus, handshake idling and the final verdict.
`timescale 1ns / 1ps

module tb_pid_controller_deadband_clamp;
  import pidc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_ITEMS = 1500;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [MEAS_W-1:0]  measured = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int fails;
  int outstanding;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  pid_controller_deadband_clamp uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .measured(measured),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pidc_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .measured(measured),
    .out_valid(out_valid), .out_ready(out_ready), .drive(drive),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Valid stays high from one item to the next when no gap is drawn.
  task automatic send_item(input logic [MEAS_W-1:0] v);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    measured <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Bits above the register's width carry random junk.
  task automatic write_field(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (w >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << w) - 1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CFG_DATA_W'($urandom()) & ~mask) | (val & mask);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_writes();
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every predicted drive value has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom());
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int sent;
    int n;
    int units;
    int off;
    bit first;
    logic [1:0] md;
    logic signed [MEAS_W-1:0] tgt;
    logic [MEAS_W-1:0] m;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: disabled, so the drive is zero.
    send_item(24'h123456);

    // Speed mode: dead band edges and the integral clamp on both sides.
    settle();
    write_field(REG_ENABLE, 24'd1, 1);
    write_field(REG_MODE, 24'(MODE_SPEED), 2);
    write_field(REG_TARGET, 24'd0, 24);
    write_field(REG_GAIN_P, 24'd256, 16);
    write_field(REG_GAIN_I, 24'd1, 16);
    write_field(REG_GAIN_D, 24'd0, 16);
    write_field(REG_LIMIT, 24'h7fff, 15);
    close_writes();
    send_item(24'd256);
    send_item(-24'sd256);
    send_item(24'd257);
    send_item(-24'sd257);
    send_item(24'h7fffff);
    send_item(24'h800000);
    send_item(24'd0);

    // Line mode: extreme gains, dead band edges, output clamp.
    settle();
    write_field(REG_MODE, 24'(MODE_LINE), 2);
    write_field(REG_GAIN_P, 24'h8000, 16);
    write_field(REG_GAIN_D, 24'h7fff, 16);
    write_field(REG_LIMIT, 24'd100, 15);
    close_writes();
    send_item(24'd768);
    send_item(24'd769);
    send_item(-24'sd769);
    send_item(-24'sd768);
    send_item(24'h7fffff);
    send_item(24'h800000);

    // Position mode with the largest target and the widest error.
    settle();
    write_field(REG_MODE, 24'(MODE_POS), 2);
    write_field(REG_TARGET, 24'h7fffff, 24);
    write_field(REG_GAIN_P, 24'h7fff, 16);
    write_field(REG_GAIN_D, 24'h8000, 16);
    close_writes();
    send_item(24'd8386047);
    send_item(24'd8386046);
    send_item(24'h800000);
    send_item(24'h7fffff);

    // A write past the register list is ignored; a zero limit forces zero.
    settle();
    write_field(REG_SPARE, 24'($urandom()), 24);
    write_field(REG_LIMIT, 24'd0, 15);
    close_writes();
    send_item(24'd0);

    // Disabled in each mode, then the unused mode enabled and disabled.
    settle();
    write_field(REG_ENABLE, 24'd0, 1);
    write_field(REG_MODE, 24'(MODE_LINE), 2);
    write_field(REG_LIMIT, 24'h7fff, 15);
    close_writes();
    send_item(24'd5000);
    settle();
    write_field(REG_MODE, 24'(MODE_POS), 2);
    close_writes();
    send_item(24'd5000);
    settle();
    write_field(REG_MODE, 24'(MODE_SPEED), 2);
    close_writes();
    send_item(24'd5000);
    settle();
    write_field(REG_ENABLE, 24'd1, 1);
    write_field(REG_MODE, 24'(MODE_NONE), 2);
    close_writes();
    send_item(24'd5000);
    settle();
    write_field(REG_ENABLE, 24'd0, 1);
    close_writes();
    send_item(24'd5000);

    // Random phases: new settings at idle, then samples mostly near the target.
    sent = 0;
    first = 1'b1;
    md = MODE_NONE;
    tgt = '0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      if (first || $urandom_range(0, 1))
        write_field(REG_ENABLE, 24'($urandom_range(0, 9) != 0), 1);
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: md = MODE_NONE;
          1, 2, 3: md = MODE_SPEED;
          4, 5, 6: md = MODE_LINE;
          default: md = MODE_POS;
        endcase
        write_field(REG_MODE, 24'(md), 2);
      end
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0: tgt = 24'h7fffff;
          1: tgt = 24'h800000;
          2: tgt = '0;
          3, 4, 5: tgt = 24'($urandom());
          default: tgt = 24'($urandom_range(0, 20480) - 10240);
        endcase
        write_field(REG_TARGET, tgt, 24);
      end
      if (first || $urandom_range(0, 1)) write_field(REG_GAIN_P, 24'(rand_gain()), 16);
      if (first || $urandom_range(0, 1)) write_field(REG_GAIN_I, 24'(rand_gain()), 16);
      if (first || $urandom_range(0, 1)) write_field(REG_GAIN_D, 24'(rand_gain()), 16);
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: write_field(REG_LIMIT, 24'd0, 15);
          1: write_field(REG_LIMIT, 24'h7fff, 15);
          2, 3: write_field(REG_LIMIT, 24'($urandom_range(1, 200)), 15);
          default: write_field(REG_LIMIT, 24'($urandom()), 15);
        endcase
      end
      if ($urandom_range(0, 3) == 0) write_field(REG_SPARE, 24'($urandom()), 24);
      close_writes();
      first = 1'b0;

      case (md)
        MODE_SPEED: units = DB_SPEED_UNITS;
        MODE_LINE:  units = DB_LINE_UNITS;
        default:    units = DB_POS_UNITS;
      endcase
      n = $urandom_range(20, 80);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // Just inside, on, or just outside the dead band.
            off = (units << FRAC_BITS) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) off = -off;
            m = tgt + MEAS_W'(off);
          end
          3, 4, 5, 6: begin
            off = int'($urandom_range(0, 32768)) - 16384;
            m = tgt + MEAS_W'(off);
          end
          default: m = MEAS_W'($urandom());
        endcase
        send_item(m);
        sent++;
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
